/* rtl/u8d_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

    localparam int CP_W    = 26;
    localparam int LEN_W   = 3;
    localparam int ST_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int OUT_DATA_W = 32;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [ST_W-1:0] ST_TRUNC    = 2'd2;

    localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;
    localparam logic [LEN_W-1:0] LEN_5 = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              buffer_end;
    } in_beat_t;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_bytes;
        logic [ST_W-1:0]  status;
        logic             end_flag;
    } result_t;

endpackage

/* rtl/u8d_core.sv */
// Sequence state and per-byte decode logic of the UTF-8 stream decoder.
module u8d_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  u8d_pkg::in_beat_t beat,
    output logic              has_result,
    output u8d_pkg::result_t  result
);

    logic [u8d_pkg::LEN_W-1:0] remaining_reg;
    logic [u8d_pkg::LEN_W-1:0] remaining_next;
    logic [u8d_pkg::LEN_W-1:0] seq_len_reg;
    logic [u8d_pkg::LEN_W-1:0] seq_len_next;
    logic [u8d_pkg::CP_W-1:0]  acc_reg;
    logic [u8d_pkg::CP_W-1:0]  acc_next;

    always_comb
    begin
        logic [u8d_pkg::CP_W-1:0]  acc_shift;
        logic [u8d_pkg::LEN_W-1:0] rem_dec;
        logic [u8d_pkg::LEN_W-1:0] lead_len;
        logic [u8d_pkg::CP_W-1:0]  lead_bits;
        logic                      lead_bad;
        logic [u8d_pkg::BYTE_W-1:0] b;

        b          = beat.data_byte;
        acc_shift  = {acc_reg[u8d_pkg::CP_W-7:0], b[5:0]};
        rem_dec    = remaining_reg - 3'd1;
        lead_bad   = 1'b0;
        lead_len   = u8d_pkg::LEN_2;
        lead_bits  = '0;

        priority if (!b[5])
        begin
            lead_len  = u8d_pkg::LEN_2;
            lead_bits = {21'd0, b[4:0]};
        end
        else if (!b[4])
        begin
            lead_len  = u8d_pkg::LEN_3;
            lead_bits = {22'd0, b[3:0]};
        end
        else if (!b[3])
        begin
            lead_len  = u8d_pkg::LEN_4;
            lead_bits = {23'd0, b[2:0]};
        end
        else if (!b[2])
        begin
            lead_len  = u8d_pkg::LEN_5;
            lead_bits = {24'd0, b[1:0]};
        end
        else
        begin
            lead_bad = 1'b1;
        end

        remaining_next = remaining_reg;
        seq_len_next   = seq_len_reg;
        acc_next       = acc_reg;
        has_result     = 1'b0;
        result.code_point = '0;
        result.seq_bytes  = u8d_pkg::LEN_1;
        result.status     = u8d_pkg::ST_OK;
        result.end_flag   = beat.buffer_end;

        if (remaining_reg != '0)
        begin
            acc_next       = acc_shift;
            remaining_next = rem_dec;
            if (rem_dec == '0)
            begin
                has_result        = 1'b1;
                result.code_point = acc_shift;
                result.seq_bytes  = seq_len_reg;
                seq_len_next      = '0;
                acc_next          = '0;
            end
            else if (beat.buffer_end)
            begin
                has_result      = 1'b1;
                result.seq_bytes = seq_len_reg - rem_dec;
                result.status   = u8d_pkg::ST_TRUNC;
                remaining_next  = '0;
                seq_len_next    = '0;
                acc_next        = '0;
            end
        end
        else if (!b[7])
        begin
            has_result        = 1'b1;
            result.code_point = {18'd0, b};
        end
        else if (lead_bad)
        begin
            has_result    = 1'b1;
            result.status = u8d_pkg::ST_BAD_LEAD;
        end
        else if (beat.buffer_end)
        begin
            has_result    = 1'b1;
            result.status = u8d_pkg::ST_TRUNC;
            seq_len_next  = '0;
            acc_next      = '0;
        end
        else
        begin
            seq_len_next   = lead_len;
            remaining_next = lead_len - 3'd1;
            acc_next       = lead_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            seq_len_reg   <= '0;
            acc_reg       <= '0;
        end
        else if (step)
        begin
            remaining_reg <= remaining_next;
            seq_len_reg   <= seq_len_next;
            acc_reg       <= acc_next;
        end
    end

endmodule

/* rtl/utf8_stream_decoder.sv */
// Top level of the UTF-8 stream decoder: input register, decode core, result register.
//
//   beat group | direction | tdata                         | tuser       | tlast
//   s_axis     | in        | [7:0] data_byte               | none        | buffer_end
//   m_axis     | out       | [25:0] code_point, [28:26]    | [1:0] status| end_flag
//              |           | seq_bytes, [31:29] zero       |             |
//
// Each byte waits in the input register until the core steps; a result it completes goes to the result register.
// A byte is taken every cycle while no result is stalled; the sequence state in the core updates on each step.
// A byte that completes nothing moves no result; the stream then gives fewer output beats.
// A stalled result holds the input register, and s_axis_tready then follows m_axis_tready.
// Reset clears the sequence state and both valid flags, so the next byte is a lead byte.
module utf8_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [25:0] code_point, [28:26] seq_bytes, [31:29] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    logic              in_valid_reg;
    logic              in_valid_next;
    u8d_pkg::in_beat_t in_beat_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    u8d_pkg::result_t  out_reg;
    logic              step;
    logic              has_result;
    u8d_pkg::result_t  result;

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    u8d_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .beat       (in_beat_reg),
        .has_result (has_result),
        .result     (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (step)
        begin
            out_valid_next = has_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_beat_reg.data_byte  <= s_axis_tdata;
            in_beat_reg.buffer_end <= s_axis_tlast;
        end
        if (step && has_result)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_reg.seq_bytes, out_reg.code_point};
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_reg.end_flag;

    a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != u8d_pkg::ST_OK) |-> (m_axis_tdata[25:0] == '0))
        else $error("error result carries a nonzero code point");

    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == u8d_pkg::ST_TRUNC) |-> m_axis_tlast)
        else $error("truncated result not marked as buffer end");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[28:26] != 3'd0) && (m_axis_tdata[28:26] <= 3'd5))
        else $error("sequence length out of range");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !step)
        else $error("core advanced while a result was stalled");

endmodule

/* bench/utf8_stream_decoder_tb.sv */
// Self-checking testbench for utf8_stream_decoder: directed bytes, then random runs.
`timescale 1ns / 100ps

module utf8_stream_decoder_tb;

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic             typed;
        u8d_pkg::result_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    logic [u8d_pkg::LEN_W-1:0] cont_left = '0;
    logic [u8d_pkg::LEN_W-1:0] seq_len   = '0;
    logic [u8d_pkg::CP_W-1:0]  cp_acc    = '0;

    u8d_pkg::result_t expected_chars[$];
    dir_row_t    dir_rows[$];
    int unsigned bytes_sent  = 0;
    int unsigned results_got = 0;
    int unsigned mismatches  = 0;
    bit          calm        = 1'b0;
    bit          sink_hold   = 1'b0;
    bit          hold_done   = 1'b0;
    bit          pause_done  = 1'b0;

    utf8_stream_decoder u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit decode_byte(input logic [7:0] b, input logic fin,
                                       output u8d_pkg::result_t r);
        logic [u8d_pkg::LEN_W-1:0] len;
        logic [u8d_pkg::CP_W-1:0]  lead_bits;
        r = '0;
        if (cont_left != '0)
        begin
            cp_acc    = {cp_acc[u8d_pkg::CP_W-7:0], b[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left == '0)
            begin
                r.code_point = cp_acc;
                r.seq_bytes  = seq_len;
                r.status     = u8d_pkg::ST_OK;
                r.end_flag   = fin;
                seq_len      = '0;
                cp_acc       = '0;
                return 1'b1;
            end
            if (fin)
            begin
                r.seq_bytes = seq_len - cont_left;
                r.status    = u8d_pkg::ST_TRUNC;
                r.end_flag  = 1'b1;
                cont_left   = '0;
                seq_len     = '0;
                cp_acc      = '0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (!b[7])
        begin
            r.code_point = {18'd0, b};
            r.seq_bytes  = u8d_pkg::LEN_1;
            r.status     = u8d_pkg::ST_OK;
            r.end_flag   = fin;
            return 1'b1;
        end
        else if (!b[5])
        begin
            len       = u8d_pkg::LEN_2;
            lead_bits = {21'd0, b[4:0]};
        end
        else if (!b[4])
        begin
            len       = u8d_pkg::LEN_3;
            lead_bits = {22'd0, b[3:0]};
        end
        else if (!b[3])
        begin
            len       = u8d_pkg::LEN_4;
            lead_bits = {23'd0, b[2:0]};
        end
        else if (!b[2])
        begin
            len       = u8d_pkg::LEN_5;
            lead_bits = {24'd0, b[1:0]};
        end
        else
        begin
            r.seq_bytes = u8d_pkg::LEN_1;
            r.status    = u8d_pkg::ST_BAD_LEAD;
            r.end_flag  = fin;
            return 1'b1;
        end
        if (fin)
        begin
            r.seq_bytes = u8d_pkg::LEN_1;
            r.status    = u8d_pkg::ST_TRUNC;
            r.end_flag  = 1'b1;
            return 1'b1;
        end
        seq_len   = len;
        cont_left = len - 3'd1;
        cp_acc    = lead_bits;
        return 1'b0;
    endfunction

    task automatic add_row(input logic [7:0] b, input logic last);
        dir_row_t row;
        row       = '0;
        row.data  = b;
        row.last  = last;
        dir_rows.push_back(row);
    endtask

    task automatic add_typed(input logic [7:0] b, input logic last,
                             input logic [u8d_pkg::CP_W-1:0] cp,
                             input logic [u8d_pkg::LEN_W-1:0] nbytes,
                             input logic [u8d_pkg::ST_W-1:0] st,
                             input logic endf);
        dir_row_t row;
        row                 = '0;
        row.data            = b;
        row.last            = last;
        row.typed           = 1'b1;
        row.want.code_point = cp;
        row.want.seq_bytes  = nbytes;
        row.want.status     = st;
        row.want.end_flag   = endf;
        dir_rows.push_back(row);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last,
                             input logic typed = 1'b0, input u8d_pkg::result_t want = '0);
        u8d_pkg::result_t pred;
        bit               produced;
        if (!calm && $urandom_range(99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
        produced = decode_byte(b, last, pred);
        if (typed)
            pred = want;
        if (produced || typed)
            expected_chars.push_back(pred);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        wait (expected_chars.size() == 0);
        @(posedge clk);
    endtask

    function automatic logic [7:0] lead_byte(input int unsigned len);
        logic [7:0] r;
        r = 8'($urandom_range(255));
        unique case (len)
            1:       lead_byte = {1'b0, r[6:0]};
            2:       lead_byte = {1'b1, r[6], 1'b0, r[4:0]};
            3:       lead_byte = {1'b1, r[6], 2'b10, r[3:0]};
            4:       lead_byte = {1'b1, r[6], 3'b110, r[2:0]};
            5:       lead_byte = {1'b1, r[6], 4'b1110, r[1:0]};
            default: lead_byte = {1'b1, r[6], 4'b1111, r[1:0]};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        logic [7:0] r;
        r = 8'($urandom_range(255));
        if ($urandom_range(99) < 85)
            r[7:6] = 2'b10;
        return r;
    endfunction

    task automatic send_random_run();
        int unsigned kind;
        int unsigned len;
        int unsigned cut;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            len = ($urandom_range(99) < 30) ? 1 : $urandom_range(2, 5);
            push_byte(lead_byte(len), (len == 1) && ($urandom_range(99) < 15));
            for (int unsigned k = 2; k <= len; k++)
                push_byte(cont_byte(), (k == len) && ($urandom_range(99) < 15));
        end
        else if (kind < 80)
        begin
            push_byte(lead_byte(0), $urandom_range(99) < 20);
        end
        else if (kind < 90)
        begin
            len = $urandom_range(2, 5);
            cut = $urandom_range(1, len - 1);
            push_byte(lead_byte(len), cut == 1);
            for (int unsigned k = 2; k <= cut; k++)
                push_byte(cont_byte(), k == cut);
        end
        else
        begin
            push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        mismatches++;
        $display("result %0d: %s is 0x%0h, expected 0x%0h", results_got, field, got_v,
                 want_v);
    endtask

    // Every accepted result beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        u8d_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch("unexpected beat", m_axis_tdata, 32'd0);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (m_axis_tdata[25:0] !== want.code_point)
                    report_mismatch("code_point", 32'(m_axis_tdata[25:0]),
                                    32'(want.code_point));
                if (m_axis_tdata[28:26] !== want.seq_bytes)
                    report_mismatch("seq_bytes", 32'(m_axis_tdata[28:26]),
                                    32'(want.seq_bytes));
                if (m_axis_tdata[31:29] !== 3'd0)
                    report_mismatch("tdata padding", 32'(m_axis_tdata[31:29]), 32'd0);
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tlast !== want.end_flag)
                    report_mismatch("end_flag", 32'(m_axis_tlast), 32'(want.end_flag));
            end
            results_got++;
        end
    end

    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                sink_hold = 1'b0;
            end
            else if (calm)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 6);
        end
    end

    initial
    begin
        #2_000_000;
        $display("utf8_stream_decoder: mismatch");
        $finish;
    end

    initial
    begin
        dir_row_t row;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;

        add_typed(8'h7F, 1'b1, 26'h7F, u8d_pkg::LEN_1, u8d_pkg::ST_OK, 1'b1);
        add_typed(8'hFF, 1'b1, '0, u8d_pkg::LEN_1, u8d_pkg::ST_BAD_LEAD, 1'b1);
        add_typed(8'hBC, 1'b0, '0, u8d_pkg::LEN_1, u8d_pkg::ST_BAD_LEAD, 1'b0);
        add_row(8'hC3, 1'b0);
        add_row(8'hA9, 1'b0);
        add_row(8'hE2, 1'b0);
        add_row(8'h82, 1'b0);
        add_row(8'hAC, 1'b0);
        add_row(8'hF0, 1'b0);
        add_row(8'h9F, 1'b0);
        add_row(8'h98, 1'b0);
        add_row(8'h80, 1'b0);
        add_row(8'hFB, 1'b0);
        add_row(8'hBF, 1'b0);
        add_row(8'hBF, 1'b0);
        add_row(8'hBF, 1'b0);
        add_typed(8'hBF, 1'b0, 26'h3FFFFFF, u8d_pkg::LEN_5, u8d_pkg::ST_OK, 1'b0);
        add_typed(8'hE0, 1'b1, '0, u8d_pkg::LEN_1, u8d_pkg::ST_TRUNC, 1'b1);
        add_row(8'hF8, 1'b0);
        add_row(8'h80, 1'b0);
        add_typed(8'h80, 1'b1, '0, u8d_pkg::LEN_3, u8d_pkg::ST_TRUNC, 1'b1);
        add_row(8'h80, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'hC0, 1'b0);
        add_row(8'hBF, 1'b1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            push_byte(row.data, row.last, row.typed, row.want);
        end
        drain_results();

        while (bytes_sent < 950)
        begin
            if (bytes_sent >= 250 && !hold_done)
            begin
                sink_hold = 1'b1;
                hold_done = 1'b1;
            end
            calm = (bytes_sent >= 450) && (bytes_sent < 600);
            if (bytes_sent >= 750 && !pause_done)
            begin
                drain_results();
                pause_done = 1'b1;
            end
            send_random_run();
        end
        calm = 1'b0;
        drain_results();
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("utf8_stream_decoder: match");
        else
            $display("utf8_stream_decoder: mismatch");
        $finish;
    end

endmodule
